/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks used by the timer table datapath
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rrtt_pkg.sv */
// ----------------------------------------------------------------------------
// rrtt_pkg
// types, codes and widths shared by the round-robin timer table
// ----------------------------------------------------------------------------
package rrtt_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned IN_TDATA_W      = 80;
  localparam int unsigned OUT_TDATA_W     = 24;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_CHANGE = 2'd2,
    OP_RUN    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_RUN,
    S_SRCH,
    S_MOVE,
    S_PUSH
  } state_e;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NEXT,
    RD_LAST,
    RD_CURSOR
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ADD,
    WR_CHANGE,
    WR_MOVE,
    WR_RUN
  } wr_op_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_FULL,
    RES_NOT_FOUND,
    RES_EMPTY,
    RES_ADD,
    RES_RUN
  } res_sel_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] due;
  } entry_t;

  typedef struct packed {
    logic     latch_in;
    logic     idx_clr;
    logic     idx_inc;
    rd_sel_e  rd_sel;
    wr_op_e   wr_op;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic count_zero;
    logic count_full;
    logic idx_last;
    logic id_match;
    logic out_busy;
  } sts_t;

endpackage

/* src/rrtt_ram.sv */
// ----------------------------------------------------------------------------
// rrtt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rrtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rrtt_ctrl.sv */
// ----------------------------------------------------------------------------
// rrtt_ctrl
// sequencer for add, delete, change and run; drives the datapath commands
// ----------------------------------------------------------------------------
module rrtt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  rrtt_pkg::op_e s_op_i,
  output logic          s_tready_o,
  input  rrtt_pkg::sts_t sts_i,
  output rrtt_pkg::cmd_t cmd_o
);
  import rrtt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_ZERO;
    cmd_o.wr_op    = WR_NONE;
    cmd_o.res_sel  = RES_NONE;
    s_tready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.latch_in = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          unique case (s_op_i)
            OP_ADD: begin
              state_d = S_ADD;
            end
            OP_RUN: begin
              cmd_o.rd_sel = RD_CURSOR;
              state_d      = S_RUN;
            end
            default: begin
              // delete and change both start the search at slot zero
              state_d = S_SRCH;
            end
          endcase
        end
      end
      S_ADD: begin
        if (sts_i.count_full) begin
          cmd_o.res_sel = RES_FULL;
        end else begin
          cmd_o.wr_op   = WR_ADD;
          cmd_o.res_sel = RES_ADD;
        end
        state_d = S_PUSH;
      end
      S_RUN: begin
        if (sts_i.count_zero) begin
          cmd_o.res_sel = RES_EMPTY;
        end else begin
          cmd_o.wr_op   = WR_RUN;
          cmd_o.res_sel = RES_RUN;
        end
        state_d = S_PUSH;
      end
      S_SRCH: begin
        priority if (sts_i.count_zero) begin
          cmd_o.res_sel = RES_NOT_FOUND;
          state_d       = S_PUSH;
        end else if (sts_i.id_match) begin
          if (sts_i.op == OP_DELETE) begin
            cmd_o.rd_sel = RD_LAST;
            state_d      = S_MOVE;
          end else begin
            cmd_o.wr_op   = WR_CHANGE;
            cmd_o.res_sel = RES_OK;
            state_d       = S_PUSH;
          end
        end else if (sts_i.idx_last) begin
          cmd_o.res_sel = RES_NOT_FOUND;
          state_d       = S_PUSH;
        end else begin
          cmd_o.idx_inc = 1'b1;
          cmd_o.rd_sel  = RD_NEXT;
        end
      end
      S_MOVE: begin
        // last entry fills the freed slot
        cmd_o.wr_op   = WR_MOVE;
        cmd_o.res_sel = RES_OK;
        state_d       = S_PUSH;
      end
      S_PUSH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* src/rrtt_dp.sv */
// ----------------------------------------------------------------------------
// rrtt_dp
// timer table datapath: entry ram, counters, cursor, adder and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrtt_dp #(
  parameter int unsigned TIMER_SLOTS = rrtt_pkg::TIMER_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rrtt_pkg::cmd_t                     cmd_i,
  output rrtt_pkg::sts_t                     sts_o,
  input  rrtt_pkg::op_e                      in_op_i,
  input  logic [rrtt_pkg::IN_TDATA_W-1:0]    in_tdata_i,
  input  logic                               m_tready_i,
  output logic                               m_tvalid_o,
  output logic [rrtt_pkg::OUT_TDATA_W-1:0]   m_tdata_o
);
  import rrtt_pkg::*;

  localparam int unsigned AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned EW = $bits(entry_t);

  // latched item
  op_e               op_q;
  logic [ID_W-1:0]   handle_q;
  logic [TIME_W-1:0] interval_q;
  logic [TIME_W-1:0] now_q;

  logic [CW-1:0]     count_q, count_d;
  logic [ID_W-1:0]   id_cnt_q, id_cnt_d;
  logic [AW-1:0]     cursor_q, cursor_d;
  logic [AW-1:0]     idx_q, idx_d;

  status_e           res_status_q, res_status_d;
  logic [ID_W-1:0]   res_handle_q, res_handle_d;
  logic              res_fired_q, res_fired_d;

  logic              out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  entry_t            rd_entry, wr_entry;
  logic [EW-1:0]     rd_raw;
  logic [AW-1:0]     raddr, waddr;
  logic              we;

  logic [AW-1:0]     cur_eff;
  logic [CW-1:0]     cur_inc;
  logic [CW-1:0]     count_m1;
  logic [TIME_W-1:0] add_b, sum, diff;
  logic              expired;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q       <= in_op_i;
      handle_q   <= in_tdata_i[ID_W-1:0];
      interval_q <= in_tdata_i[ID_W +: TIME_W];
      now_q      <= in_tdata_i[ID_W+TIME_W +: TIME_W];
    end
  end

  // a cursor beyond the live entries reads as slot zero
  assign cur_eff  = (CW'(cursor_q) >= count_q) ? '0 : cursor_q;
  assign cur_inc  = CW'(cur_eff) + CW'(1);
  assign count_m1 = count_q - CW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ZERO:   raddr = '0;
      RD_NEXT:   raddr = idx_q + AW'(1);
      RD_LAST:   raddr = AW'(count_m1);
      RD_CURSOR: raddr = cur_eff;
      default:   raddr = '0;
    endcase
  end

  rrtt_ram #(
    .WIDTH (EW),
    .DEPTH (TIMER_SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_entry),
    .raddr_i (raddr),
    .rdata_o (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  assign add_b   = (cmd_i.wr_op == WR_RUN) ? rd_entry.period : interval_q;
  assign sum     = now_q + add_b;
  // wrap-safe expiry: signed distance from due time is not negative
  assign diff    = now_q - rd_entry.due;
  assign expired = ~diff[TIME_W-1];

  always_comb begin
    we       = 1'b0;
    waddr    = idx_q;
    wr_entry = rd_entry;
    count_d  = count_q;
    id_cnt_d = id_cnt_q;
    cursor_d = cursor_q;
    unique case (cmd_i.wr_op)
      WR_ADD: begin
        we              = 1'b1;
        waddr           = AW'(count_q);
        wr_entry.id     = id_cnt_q;
        wr_entry.period = interval_q;
        wr_entry.due    = sum;
        count_d         = count_q + CW'(1);
        id_cnt_d        = id_cnt_q + ID_W'(1);
      end
      WR_CHANGE: begin
        we              = 1'b1;
        wr_entry.period = interval_q;
        wr_entry.due    = sum;
      end
      WR_MOVE: begin
        we      = 1'b1;
        count_d = count_m1;
        if (CW'(cursor_q) >= count_m1) begin
          cursor_d = '0;
        end
      end
      WR_RUN: begin
        we           = expired;
        waddr        = cur_eff;
        wr_entry.due = sum;
        cursor_d     = (cur_inc >= count_q) ? '0 : AW'(cur_inc);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_comb begin
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_fired_d  = res_fired_q;
    unique case (cmd_i.res_sel)
      RES_OK: begin
        res_status_d = ST_OK;
        res_handle_d = '0;
        res_fired_d  = 1'b0;
      end
      RES_FULL: begin
        res_status_d = ST_FULL;
        res_handle_d = '0;
        res_fired_d  = 1'b0;
      end
      RES_NOT_FOUND: begin
        res_status_d = ST_NOT_FOUND;
        res_handle_d = '0;
        res_fired_d  = 1'b0;
      end
      RES_EMPTY: begin
        res_status_d = ST_EMPTY;
        res_handle_d = '0;
        res_fired_d  = 1'b0;
      end
      RES_ADD: begin
        res_status_d = ST_OK;
        res_handle_d = id_cnt_q;
        res_fired_d  = 1'b0;
      end
      RES_RUN: begin
        res_status_d = ST_OK;
        res_handle_d = expired ? rd_entry.id : '0;
        res_fired_d  = expired;
      end
      default: begin
        res_fired_d = res_fired_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_fired_q  <= res_fired_d;
    if (cmd_i.out_load) begin
      out_data_q <= OUT_TDATA_W'({res_fired_q, res_handle_q, res_status_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      id_cnt_q    <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      id_cnt_q <= id_cnt_d;
      cursor_q <= cursor_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  assign sts_o.op         = op_q;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_full = (count_q == CW'(TIMER_SLOTS));
  assign sts_o.idx_last   = (CW'(idx_q) == count_m1);
  assign sts_o.id_match   = (rd_entry.id == handle_q);
  assign sts_o.out_busy   = out_valid_q & ~m_tready_i;

  `ASSERT_ALWAYS(a_count_range, count_q <= CW'(TIMER_SLOTS), "live count beyond table size")
  `ASSERT_IMPLY(a_cursor_empty, count_q == '0, cursor_q == '0, "cursor off zero on empty table")
  `ASSERT_IMPLY(a_cursor_live, count_q != '0, CW'(cursor_q) < count_q, "cursor past live entries")
  `ASSERT_NEXT(a_add_count, cmd_i.wr_op == WR_ADD, count_q == $past(count_q) + CW'(1),
               "add did not grow the table")

endmodule

/* src/round_robin_timer_table.sv */
// ----------------------------------------------------------------------------
// round_robin_timer_table
// table of periodic timers managed by add, delete, change and run items
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation per item: tuser holds the operation code,
//   tdata holds the timer handle, the interval and the current time.
//   m_axis returns exactly one result item per accepted item: status,
//   handle and fired flag, in tdata.
//   timing: add and run go from acceptance through S_ADD or S_RUN to
//   S_PUSH, which waits for a free output register and then loads it;
//   delete and change first scan the table one slot per cycle through the
//   entry ram read port in S_SRCH (a delete that finds its id also passes
//   S_MOVE). one item is in work at a time; the next is taken the cycle
//   after the result has gone into the output register, which drives
//   m_axis_tvalid.
//   reset empties the table, zeroes the id counter and the cursor; the
//   entry ram itself is not cleared and no pass over it is made.
//   a stalled receiver holds the result in the output register; one
//   further item may be accepted and worked, and waits until it is free.
// ----------------------------------------------------------------------------
module round_robin_timer_table #(
  parameter int unsigned TIMER_SLOTS = rrtt_pkg::TIMER_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // timer_handle[15:0], interval_ms[47:16], now_ms[79:48]
  input  logic [rrtt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[1:0], result_handle[17:2], fired[18], zero[23:19]
  output logic [rrtt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import rrtt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  op_e  s_op;

  assign s_op = op_e'(s_axis_tuser);

  rrtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_op_i     (s_op),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrtt_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_op_i    (s_op),
    .in_tdata_i (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

/* tb/sv/tb_round_robin_timer_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_timer_table
// self-checking bench: a timer table model predicts every result item
// ----------------------------------------------------------------------------
// a short directed pass covers the empty, full and wrap-around time cases,
// then random traffic in segments with different operation mixes, sender
// gaps and receiver stalls follows. results are checked in order.
// ----------------------------------------------------------------------------
import rrtt_pkg::*;

typedef struct {
  status_e     status;
  logic [15:0] handle;
  logic        fired;
} reply_t;

class timer_table_board;
  logic [31:0]  due_ms    [TIMER_SLOTS_DEF];
  logic [31:0]  period_ms [TIMER_SLOTS_DEF];
  logic [15:0]  slot_id   [TIMER_SLOTS_DEF];
  int unsigned  live;
  logic [15:0]  next_id;
  int unsigned  cursor;
  reply_t       replies_owed[$];
  int unsigned  errors;

  function new();
    live    = 0;
    next_id = '0;
    cursor  = 0;
    errors  = 0;
  endfunction

  function int pending();
    return replies_owed.size();
  endfunction

  // lowest slot holding the id wins
  function int find_id(logic [15:0] h);
    for (int i = 0; i < live; i++) begin
      if (slot_id[i] == h) return i;
    end
    return -1;
  endfunction

  // apply one accepted item to the table copy and queue the reply it owes
  function void note_op(op_e op, logic [15:0] h, logic [31:0] ivl, logic [31:0] now);
    reply_t      r;
    int          s;
    int unsigned c;
    logic [31:0] late;
    r.status = ST_OK;
    r.handle = '0;
    r.fired  = 1'b0;
    case (op)
      OP_ADD: begin
        if (live >= TIMER_SLOTS_DEF) begin
          r.status = ST_FULL;
        end else begin
          due_ms[live]    = now + ivl;
          period_ms[live] = ivl;
          slot_id[live]   = next_id;
          r.handle        = next_id;
          next_id         = next_id + 16'd1;
          live++;
        end
      end
      OP_DELETE: begin
        s = find_id(h);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          due_ms[s]    = due_ms[live-1];
          period_ms[s] = period_ms[live-1];
          slot_id[s]   = slot_id[live-1];
          live--;
          if (cursor >= live) cursor = 0;
        end
      end
      OP_CHANGE: begin
        s = find_id(h);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          due_ms[s]    = now + ivl;
          period_ms[s] = ivl;
        end
      end
      default: begin
        if (live == 0) begin
          r.status = ST_EMPTY;
        end else begin
          c = (cursor >= live) ? 0 : cursor;
          // expired when now - due is non-negative as a signed value
          late = now - due_ms[c];
          if (!late[31]) begin
            r.fired   = 1'b1;
            r.handle  = slot_id[c];
            due_ms[c] = now + period_ms[c];
          end
          c++;
          cursor = (c >= live) ? 0 : c;
        end
      end
    endcase
    replies_owed.push_back(r);
  endfunction

  function void check_reply(logic [OUT_TDATA_W-1:0] td);
    reply_t want;
    if (replies_owed.size() == 0) begin
      errors++;
      $error("result item with nothing pending: %h", td);
      return;
    end
    want = replies_owed.pop_front();
    if (td[1:0] !== want.status) begin
      errors++;
      $error("status: expected %0d, got %0d", want.status, td[1:0]);
    end
    if (td[17:2] !== want.handle) begin
      errors++;
      $error("result_handle: expected %0d, got %0d", want.handle, td[17:2]);
    end
    if (td[18] !== want.fired) begin
      errors++;
      $error("fired: expected %0d, got %0d", want.fired, td[18]);
    end
  endfunction
endclass

module tb_round_robin_timer_table;

  localparam int unsigned SLOTS = TIMER_SLOTS_DEF;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  timer_table_board board = new();

  bit          tx_idle_en;
  int unsigned burst_left;
  int unsigned rx_mode;
  int unsigned rx_hold;
  logic [31:0] clock_ms;

  round_robin_timer_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // offer one item and hold it until the block takes it
  task automatic send_op(op_e op, logic [15:0] h, logic [31:0] ivl, logic [31:0] now);
    int unsigned gap;
    @(negedge clk_i);
    if (tx_idle_en && burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap        = $urandom_range(6);
      repeat (gap) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {now, ivl, h};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_op(op, h, ivl, now);
  endtask

  task automatic wait_for_drain(int unsigned settle);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_interval();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3, 4:    return $urandom();
      default: return $urandom_range(60);
    endcase
  endfunction

  // mostly small steps so that timers come due, now and then a jump anywhere
  function automatic logic [31:0] advance_clock();
    if ($urandom_range(19) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(15);
    return clock_ms;
  endfunction

  function automatic logic [15:0] pick_handle();
    if (board.live > 0 && $urandom_range(3) != 0)
      return board.slot_id[$urandom_range(board.live - 1)];
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // operation mix per segment: add heavy, delete heavy, run heavy, even
  function automatic op_e pick_op(int unsigned profile);
    int unsigned r;
    int unsigned add_pct;
    int unsigned del_pct;
    int unsigned chg_pct;
    r = $urandom_range(99);
    case (profile)
      0:       begin add_pct = 55; del_pct = 15; chg_pct = 10; end
      1:       begin add_pct = 20; del_pct = 45; chg_pct = 10; end
      2:       begin add_pct = 15; del_pct = 10; chg_pct = 15; end
      default: begin add_pct = 25; del_pct = 25; chg_pct = 25; end
    endcase
    if (r < add_pct) return OP_ADD;
    if (r < add_pct + del_pct) return OP_DELETE;
    if (r < add_pct + del_pct + chg_pct) return OP_CHANGE;
    return OP_RUN;
  endfunction

  // receiver: always ready, random stalls, or a fixed stall pattern
  initial begin
    int unsigned tick;
    tick          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (rx_hold > 0) begin
        m_axis_tready = 1'b0;
        rx_hold--;
      end else begin
        case (rx_mode)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = ($urandom_range(2) != 0);
          default: m_axis_tready = ((tick % 9) < 5);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_reply(m_axis_tdata);
  end

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned seg;
    int unsigned n;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    tx_idle_en    = 1'b0;
    burst_left    = 0;
    rx_mode       = 0;
    rx_hold       = 0;
    clock_ms      = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table: run, delete and change all miss
    send_op(OP_RUN,    16'h0000, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_DELETE, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(OP_CHANGE, 16'hFFFF, 32'h0000_1234, 32'hFFFF_FFFF);
    // zero interval, due time wrap, half-range interval
    send_op(OP_ADD,    16'hFFFF, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_ADD,    16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_ADD,    16'h5A5A, 32'h8000_0000, 32'd5);
    // due exactly now, one short of due, furthest positive distance
    send_op(OP_RUN,    16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    send_op(OP_RUN,    16'h0000, 32'h0000_0000, 32'hFFFF_FFFD);
    send_op(OP_RUN,    16'h0000, 32'h0000_0000, 32'd4);
    send_op(OP_CHANGE, 16'd1,    32'd10,        32'd100);
    send_op(OP_RUN,    16'h0000, 32'h0000_0000, 32'd109);
    send_op(OP_RUN,    16'h0000, 32'h0000_0000, 32'd110);
    // delete with the cursor past the new count
    send_op(OP_DELETE, 16'd0,    32'h0000_0000, 32'd110);
    clock_ms = 32'd200;
    while (board.live < SLOTS)
      send_op(OP_ADD, 16'($urandom_range(16'hFFFF)), pick_interval(), advance_clock());
    send_op(OP_ADD, 16'h0000, 32'd7, advance_clock());
    send_op(OP_DELETE, board.slot_id[board.live-1], 32'd0, clock_ms);
    wait_for_drain(0);

    for (seg = 0; seg < 12; seg++) begin
      tx_idle_en = (seg % 3) != 0;
      rx_mode    = seg % 3;
      burst_left = 0;
      // long receiver hold while the sender keeps offering
      if (seg == 2) rx_hold = 200;
      for (n = 0; n < 100; n++)
        send_op(pick_op(seg % 4), pick_handle(), pick_interval(), advance_clock());
      if (seg % 2 == 1) wait_for_drain(0);
    end

    wait_for_drain(SLOTS + 8);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
